// ----- hdl/xeu_pkg.sv -----
// Package: shared types, codes and entity tables for the XML entity unescape unit.
`default_nettype none
package xeu_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CHAR_W      = 16;

    // match progress codes: the prefix held back so far
    localparam logic [3:0] CODE_IDLE = 4'd0;
    localparam logic [3:0] CODE_AMP  = 4'd1;   // &
    localparam logic [3:0] CODE_A    = 4'd2;   // &a
    localparam logic [3:0] CODE_AM   = 4'd3;   // &am
    localparam logic [3:0] CODE_AMPF = 4'd4;   // &amp
    localparam logic [3:0] CODE_L    = 4'd5;   // &l
    localparam logic [3:0] CODE_LT   = 4'd6;   // &lt
    localparam logic [3:0] CODE_G    = 4'd7;   // &g
    localparam logic [3:0] CODE_GT   = 4'd8;   // &gt
    localparam logic [3:0] CODE_Q    = 4'd9;   // &q
    localparam logic [3:0] CODE_QU   = 4'd10;  // &qu
    localparam logic [3:0] CODE_QUO  = 4'd11;  // &quo
    localparam logic [3:0] CODE_QUOT = 4'd12;  // &quot

    localparam logic [15:0] CH_AMP  = 16'h0026;
    localparam logic [15:0] CH_LT   = 16'h003C;
    localparam logic [15:0] CH_GT   = 16'h003E;
    localparam logic [15:0] CH_QUOT = 16'h0022;
    localparam logic [15:0] CH_SEMI = 16'h003B;
    localparam logic [15:0] CH_A    = 16'h0061;
    localparam logic [15:0] CH_G    = 16'h0067;
    localparam logic [15:0] CH_L    = 16'h006C;
    localparam logic [15:0] CH_M    = 16'h006D;
    localparam logic [15:0] CH_O    = 16'h006F;
    localparam logic [15:0] CH_P    = 16'h0070;
    localparam logic [15:0] CH_Q    = 16'h0071;
    localparam logic [15:0] CH_T    = 16'h0074;
    localparam logic [15:0] CH_U    = 16'h0075;

    // index of the sixth result of a command; one command can expand to six results
    localparam logic [2:0] RESULT_LIMIT = 3'd5;

    // one command from front to back: held prefix, then an optional character
    typedef struct packed {
        logic [3:0]        pfx;
        logic              has_char;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic head_valid;
        logic second_valid;
    } q_stat_t;

    function automatic logic [2:0] held_len(input logic [3:0] code);
        logic [2:0] n;
        case (code)
            CODE_AMP:                                      n = 3'd1;
            CODE_A, CODE_L, CODE_G, CODE_Q:                n = 3'd2;
            CODE_AM, CODE_LT, CODE_GT, CODE_QU:            n = 3'd3;
            CODE_AMPF, CODE_QUO:                           n = 3'd4;
            CODE_QUOT:                                     n = 3'd5;
            default:                                       n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [15:0] held_char(input logic [3:0] code, input logic [2:0] idx);
        logic [39:0] txt;
        logic [2:0]  n;
        logic [2:0]  pos;
        case (code)
            CODE_AMP:  txt = {32'h0, "&"};
            CODE_A:    txt = {24'h0, "&a"};
            CODE_AM:   txt = {16'h0, "&am"};
            CODE_AMPF: txt = {8'h0, "&amp"};
            CODE_L:    txt = {24'h0, "&l"};
            CODE_LT:   txt = {16'h0, "&lt"};
            CODE_G:    txt = {24'h0, "&g"};
            CODE_GT:   txt = {16'h0, "&gt"};
            CODE_Q:    txt = {24'h0, "&q"};
            CODE_QU:   txt = {16'h0, "&qu"};
            CODE_QUO:  txt = {8'h0, "&quo"};
            CODE_QUOT: txt = "&quot";
            default:   txt = 40'h0;
        endcase
        n   = held_len(code);
        pos = n - 3'd1 - idx;
        return {8'h00, txt[{pos, 3'b000} +: 8]};
    endfunction

endpackage
`default_nettype wire

// ----- hdl/xeu_front.sv -----
// Front end: accepts characters, tracks entity matching, issues commands to the queue.
`default_nettype none
module xeu_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 q_full,
    output logic                      q_push,
    output xeu_pkg::cmd_t             q_cmd
);

    logic [3:0] progress_reg, progress_next;
    logic       pending_reg, pending_next;

    logic        accept;
    logic [3:0]  s;
    logic [3:0]  pfx;
    logic        has_char;
    logic [15:0] ch;
    logic [3:0]  np;
    logic        fresh;
    logic [15:0] want;
    logic [3:0]  adv;
    logic [15:0] repl;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        want = 16'h0000;
        adv  = xeu_pkg::CODE_IDLE;
        repl = 16'h0000;
        case (s)
            xeu_pkg::CODE_A:    begin want = xeu_pkg::CH_M;    adv = xeu_pkg::CODE_AM;   end
            xeu_pkg::CODE_AM:   begin want = xeu_pkg::CH_P;    adv = xeu_pkg::CODE_AMPF; end
            xeu_pkg::CODE_AMPF: begin want = xeu_pkg::CH_SEMI; repl = xeu_pkg::CH_AMP;   end
            xeu_pkg::CODE_L:    begin want = xeu_pkg::CH_T;    adv = xeu_pkg::CODE_LT;   end
            xeu_pkg::CODE_LT:   begin want = xeu_pkg::CH_SEMI; repl = xeu_pkg::CH_LT;    end
            xeu_pkg::CODE_G:    begin want = xeu_pkg::CH_T;    adv = xeu_pkg::CODE_GT;   end
            xeu_pkg::CODE_GT:   begin want = xeu_pkg::CH_SEMI; repl = xeu_pkg::CH_GT;    end
            xeu_pkg::CODE_Q:    begin want = xeu_pkg::CH_U;    adv = xeu_pkg::CODE_QU;   end
            xeu_pkg::CODE_QU:   begin want = xeu_pkg::CH_O;    adv = xeu_pkg::CODE_QUO;  end
            xeu_pkg::CODE_QUO:  begin want = xeu_pkg::CH_T;    adv = xeu_pkg::CODE_QUOT; end
            xeu_pkg::CODE_QUOT: begin want = xeu_pkg::CH_SEMI; repl = xeu_pkg::CH_QUOT;  end
            default:            begin want = 16'h0000;         adv = xeu_pkg::CODE_IDLE; end
        endcase
    end

    always_comb
    begin
        s        = (progress_reg > xeu_pkg::CODE_QUOT) ? xeu_pkg::CODE_IDLE : progress_reg;
        pfx      = xeu_pkg::CODE_IDLE;
        has_char = 1'b0;
        ch       = s_tdata;
        np       = xeu_pkg::CODE_IDLE;
        fresh    = 1'b0;

        if (s == xeu_pkg::CODE_IDLE)
        begin
            fresh = 1'b1;
        end
        else if (s == xeu_pkg::CODE_AMP)
        begin
            if (s_tdata == xeu_pkg::CH_A)
                np = xeu_pkg::CODE_A;
            else if (s_tdata == xeu_pkg::CH_L)
                np = xeu_pkg::CODE_L;
            else if (s_tdata == xeu_pkg::CH_G)
                np = xeu_pkg::CODE_G;
            else if (s_tdata == xeu_pkg::CH_Q)
                np = xeu_pkg::CODE_Q;
            else
            begin
                pfx   = s;
                fresh = 1'b1;
            end
        end
        else if (s_tdata == want)
        begin
            if (repl != 16'h0000)
            begin
                has_char = 1'b1;
                ch       = repl;
            end
            else
                np = adv;
        end
        else
        begin
            pfx   = s;
            fresh = 1'b1;
        end

        if (fresh)
        begin
            if (s_tdata == xeu_pkg::CH_AMP)
                np = xeu_pkg::CODE_AMP;
            else
                has_char = 1'b1;
        end

        // end of string: flush whatever is still held
        if (s_tlast && np != xeu_pkg::CODE_IDLE)
        begin
            if (pfx == xeu_pkg::CODE_IDLE)
                pfx = np;
            else
            begin
                has_char = 1'b1;
                ch       = xeu_pkg::CH_AMP;
            end
            np = xeu_pkg::CODE_IDLE;
        end
    end

    assign q_push = accept && (pfx != xeu_pkg::CODE_IDLE || has_char || pending_reg);

    always_comb
    begin
        q_cmd.pfx      = pfx;
        q_cmd.has_char = has_char;
        q_cmd.ch       = ch;
        q_cmd.last     = s_tlast;
    end

    always_comb
    begin
        progress_next = progress_reg;
        pending_next  = pending_reg;
        if (accept)
            progress_next = np;
        if (q_push)
            pending_next = (pfx == xeu_pkg::CODE_QUOT) && has_char;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg <= xeu_pkg::CODE_IDLE;
            pending_reg  <= 1'b0;
        end
        else
        begin
            progress_reg <= progress_next;
            pending_reg  <= pending_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/xeu_queue.sv -----
// Command queue between front and back ends.
`default_nettype none
module xeu_queue
#(
    parameter int DEPTH = xeu_pkg::QUEUE_DEPTH
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire xeu_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output xeu_pkg::cmd_t       head,
    output xeu_pkg::q_stat_t    stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    xeu_pkg::cmd_t entry_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        stat.full         = (count_reg == CW'(DEPTH));
        stat.head_valid   = (count_reg != '0);
        stat.second_valid = (count_reg > CW'(1));
    end

endmodule
`default_nettype wire

// ----- hdl/xeu_back.sv -----
// Back end: expands commands into output characters through an output register.
`default_nettype none
module xeu_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire xeu_pkg::cmd_t     head,
    input  wire xeu_pkg::q_stat_t  stat,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,
    output logic                   m_tlast
);

    logic [2:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [15:0] data_reg, data_next;
    logic        last_reg, last_next;

    logic [2:0]  plen;
    logic [2:0]  total;
    logic        load_ok;
    logic        emit;
    logic        is_final;

    assign plen     = xeu_pkg::held_len(head.pfx);
    assign total    = plen + {2'b00, head.has_char};
    assign load_ok  = !valid_reg || m_tready;
    assign is_final = (idx_reg == total - 3'd1);

    always_comb
    begin
        emit = 1'b0;
        pop  = 1'b0;
        if (stat.head_valid && load_ok)
        begin
            if (total == 3'd0)
                pop = 1'b1;
            // the sixth character waits for the next item to arrive
            else if (idx_reg != xeu_pkg::RESULT_LIMIT || stat.second_valid)
            begin
                emit = 1'b1;
                pop  = is_final;
            end
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (load_ok)
            valid_next = emit;
        if (emit)
        begin
            data_next = (idx_reg < plen) ? xeu_pkg::held_char(head.pfx, idx_reg) : head.ch;
            last_next = head.last && is_final;
            idx_next  = is_final ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

// ----- hdl/xml_entity_unescape_unit.sv -----
// Top level: XML entity unescape unit for a stream of 16-bit characters.
// Usage:
//   Slave channel s_*: one character per beat, s_tlast on the final character
//   of a string. Master channel m_*: unescaped characters, m_tlast on the
//   final character of each string.
//   &amp; &lt; &gt; &quot; become & < > "; other text passes unchanged.
// Throughput: one input beat per cycle while the command queue has room;
//   one output beat per cycle while m_tready is high. A beat can yield up to
//   six characters, one per output beat; the queue absorbs short bursts.
// Path: a taken beat is written into the command queue and then into the
//   output register, once its entity (if any) is resolved. After a break
//   of a full "&quot" prefix the sixth character waits for the next input beat.
// Reset: rst_n low clears matching state, queue and the output valid flag;
//   s_tready is high right after reset.
// Stall: with m_tready low the output holds its beat; the queue fills and
//   then s_tready drops until the receiver takes beats again.
`default_nettype none
module xml_entity_unescape_unit
#(
    parameter int QUEUE_DEPTH = xeu_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] char_in
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] char_out
    output logic             m_tlast
);

    logic              q_push;
    logic              q_pop;
    xeu_pkg::cmd_t     q_cmd;
    xeu_pkg::cmd_t     q_head;
    xeu_pkg::q_stat_t  q_stat;

    xeu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_stat.full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    xeu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    xeu_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .stat     (q_stat),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ----- hdl/xeu_checker.sv -----
// Port-level checker for the XML entity unescape unit, with its bind.
`default_nettype none
module xeu_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_out_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
        else $error("output beat right after reset");

    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> s_tready)
        else $error("input not ready after reset");

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown({s_tdata, s_tlast}))
        else $error("input beat carries unknown bits");

endmodule

bind xml_entity_unescape_unit xeu_checker u_xeu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- sim/xml_entity_unescape_unit_test.sv -----
// Testbench: XML entity unescape unit checked beat by beat against a built-in predictor.
`timescale 1ns / 100ps
module xml_entity_unescape_unit_test;

    localparam int ENT_AMP  = 0;
    localparam int ENT_LT   = 1;
    localparam int ENT_GT   = 2;
    localparam int ENT_QUOT = 3;
    localparam int BEAT_LIMIT = 5;
    localparam logic [15:0] PLAIN_CH = 16'h005A;

    typedef struct packed {
        logic [15:0] ch;
        logic        lst;
    } out_char_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] char_in
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] char_out
    logic        m_tlast;

    logic        idle_on = 1'b1;
    int          bad_count = 0;

    logic [3:0]  progress = xeu_pkg::CODE_IDLE;
    logic        slot_vld = 1'b0;
    out_char_t   slot_val;
    out_char_t   step_buf [$];
    out_char_t   expected_chars [$];

    xml_entity_unescape_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    function automatic logic [0:5][15:0] spelling(input int which);
        case (which)
            ENT_AMP: return {xeu_pkg::CH_AMP, xeu_pkg::CH_A, xeu_pkg::CH_M, xeu_pkg::CH_P,
                             xeu_pkg::CH_SEMI, 16'h0000};
            ENT_LT:  return {xeu_pkg::CH_AMP, xeu_pkg::CH_L, xeu_pkg::CH_T,
                             xeu_pkg::CH_SEMI, 32'h0};
            ENT_GT:  return {xeu_pkg::CH_AMP, xeu_pkg::CH_G, xeu_pkg::CH_T,
                             xeu_pkg::CH_SEMI, 32'h0};
            default: return {xeu_pkg::CH_AMP, xeu_pkg::CH_Q, xeu_pkg::CH_U, xeu_pkg::CH_O,
                             xeu_pkg::CH_T, xeu_pkg::CH_SEMI};
        endcase
    endfunction

    function automatic int spell_len(input int which);
        case (which)
            ENT_AMP:  return 5;
            ENT_QUOT: return 6;
            default:  return 4;
        endcase
    endfunction

    // ---------------- predictor ----------------
    function automatic void emit(input logic [15:0] ch, input logic lst);
        out_char_t oc;
        oc.ch  = ch;
        oc.lst = lst;
        step_buf.push_back(oc);
    endfunction

    function automatic void release_prefix(input logic [3:0] code);
        logic [0:5][15:0] word;
        int n;
        word = spelling(ENT_AMP);
        n = 0;
        case (code)
            xeu_pkg::CODE_AMP, xeu_pkg::CODE_A, xeu_pkg::CODE_AM, xeu_pkg::CODE_AMPF:
            begin
                word = spelling(ENT_AMP);
                n = code - xeu_pkg::CODE_AMP + 1;
            end
            xeu_pkg::CODE_L, xeu_pkg::CODE_LT:
            begin
                word = spelling(ENT_LT);
                n = code - xeu_pkg::CODE_L + 2;
            end
            xeu_pkg::CODE_G, xeu_pkg::CODE_GT:
            begin
                word = spelling(ENT_GT);
                n = code - xeu_pkg::CODE_G + 2;
            end
            xeu_pkg::CODE_Q, xeu_pkg::CODE_QU, xeu_pkg::CODE_QUO, xeu_pkg::CODE_QUOT:
            begin
                word = spelling(ENT_QUOT);
                n = code - xeu_pkg::CODE_Q + 2;
            end
            default: n = 0;
        endcase
        for (int i = 0; i < n; i++)
            emit(word[i], 1'b0);
    endfunction

    function automatic void scan_char(input logic [15:0] c);
        if (c == xeu_pkg::CH_AMP)
            progress = xeu_pkg::CODE_AMP;
        else
            emit(c, 1'b0);
    endfunction

    function automatic void unescape_beat(input logic [15:0] c, input logic lst);
        logic [3:0]  s;
        logic [15:0] want;
        logic [3:0]  nxt;
        logic [15:0] repl;
        logic        has_repl;
        out_char_t   tail;
        step_buf.delete();
        if (slot_vld)
        begin
            step_buf.push_back(slot_val);
            slot_vld = 1'b0;
        end
        s = (progress > xeu_pkg::CODE_QUOT) ? xeu_pkg::CODE_IDLE : progress;
        want = 16'h0000;
        nxt = xeu_pkg::CODE_IDLE;
        repl = 16'h0000;
        has_repl = 1'b0;
        case (s)
            xeu_pkg::CODE_A:    begin want = xeu_pkg::CH_M; nxt = xeu_pkg::CODE_AM;   end
            xeu_pkg::CODE_AM:   begin want = xeu_pkg::CH_P; nxt = xeu_pkg::CODE_AMPF; end
            xeu_pkg::CODE_AMPF:
            begin
                want = xeu_pkg::CH_SEMI;
                repl = xeu_pkg::CH_AMP;
                has_repl = 1'b1;
            end
            xeu_pkg::CODE_L:    begin want = xeu_pkg::CH_T; nxt = xeu_pkg::CODE_LT;   end
            xeu_pkg::CODE_LT:
            begin
                want = xeu_pkg::CH_SEMI;
                repl = xeu_pkg::CH_LT;
                has_repl = 1'b1;
            end
            xeu_pkg::CODE_G:    begin want = xeu_pkg::CH_T; nxt = xeu_pkg::CODE_GT;   end
            xeu_pkg::CODE_GT:
            begin
                want = xeu_pkg::CH_SEMI;
                repl = xeu_pkg::CH_GT;
                has_repl = 1'b1;
            end
            xeu_pkg::CODE_Q:    begin want = xeu_pkg::CH_U; nxt = xeu_pkg::CODE_QU;   end
            xeu_pkg::CODE_QU:   begin want = xeu_pkg::CH_O; nxt = xeu_pkg::CODE_QUO;  end
            xeu_pkg::CODE_QUO:  begin want = xeu_pkg::CH_T; nxt = xeu_pkg::CODE_QUOT; end
            xeu_pkg::CODE_QUOT:
            begin
                want = xeu_pkg::CH_SEMI;
                repl = xeu_pkg::CH_QUOT;
                has_repl = 1'b1;
            end
            default: ;
        endcase

        if (s == xeu_pkg::CODE_IDLE)
        begin
            progress = xeu_pkg::CODE_IDLE;
            scan_char(c);
        end
        else if (s == xeu_pkg::CODE_AMP)
        begin
            if (c == xeu_pkg::CH_A)
                progress = xeu_pkg::CODE_A;
            else if (c == xeu_pkg::CH_L)
                progress = xeu_pkg::CODE_L;
            else if (c == xeu_pkg::CH_G)
                progress = xeu_pkg::CODE_G;
            else if (c == xeu_pkg::CH_Q)
                progress = xeu_pkg::CODE_Q;
            else
            begin
                release_prefix(s);
                progress = xeu_pkg::CODE_IDLE;
                scan_char(c);
            end
        end
        else if (c == want)
        begin
            if (has_repl)
            begin
                emit(repl, 1'b0);
                progress = xeu_pkg::CODE_IDLE;
            end
            else
                progress = nxt;
        end
        else
        begin
            release_prefix(s);
            progress = xeu_pkg::CODE_IDLE;
            scan_char(c);
        end

        if (lst)
        begin
            release_prefix(progress);
            progress = xeu_pkg::CODE_IDLE;
            if (step_buf.size() > 0)
            begin
                tail = step_buf.pop_back();
                tail.lst = 1'b1;
                step_buf.push_back(tail);
            end
        end

        // a sixth character waits for the next beat
        if (step_buf.size() > BEAT_LIMIT)
        begin
            slot_val = step_buf.pop_back();
            slot_vld = 1'b1;
        end
        for (int i = 0; i < step_buf.size(); i++)
            expected_chars.push_back(step_buf[i]);
    endfunction

    // ---------------- checker ----------------
    always @(posedge clk)
    begin : char_checker
        out_char_t want_char;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                unescape_beat(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected beat: char %h last %b", m_tdata, m_tlast);
                end
                else
                begin
                    want_char = expected_chars.pop_front();
                    if (m_tdata !== want_char.ch || m_tlast !== want_char.lst)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("mismatch: expected char %h last %b, got char %h last %b",
                                     want_char.ch, want_char.lst, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    // ---------------- receiver pacing ----------------
    initial
    begin : rx_pacing
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // ---------------- sender ----------------
    task automatic send_char(input logic [15:0] ch, input logic lst);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_word(input string txt, input logic lst);
        for (int i = 0; i < txt.len(); i++)
            send_char({8'h00, txt[i]}, lst && (i == txt.len() - 1));
    endtask

    task automatic test_entities();
        send_word("&amp;lt;", 1'b1);
        send_word("&gt;", 1'b1);
        send_word("&quot;", 1'b0);
    endtask

    task automatic test_quot_overflow();
        send_word("&quot", 1'b0);
        send_char(16'hFFFF, 1'b1);
        send_char(16'h0000, 1'b1);
    endtask

    task automatic test_broken_match();
        send_word("&a&lt", 1'b1);
    endtask

    task automatic test_wide_chars();
        send_char(16'h0126, 1'b0);
        send_char(16'h8061, 1'b1);
    endtask

    task automatic test_random_text(input int n_items);
        logic [15:0]      text_q [$];
        logic [0:5][15:0] word;
        logic [7:0]       hi;
        int               n_tok;
        int               pick;
        int               which;
        int               cut;
        int               sent;
        sent = 0;
        while (sent < n_items)
        begin
            text_q.delete();
            n_tok = $urandom_range(1, 4);
            repeat (n_tok)
            begin
                pick  = $urandom_range(0, 99);
                which = $urandom_range(ENT_AMP, ENT_QUOT);
                word  = spelling(which);
                cut   = $urandom_range(1, spell_len(which) - 1);
                if (pick < 35)
                begin
                    for (int i = 0; i < spell_len(which); i++)
                        text_q.push_back(word[i]);
                end
                else if (pick < 55)
                begin
                    for (int i = 0; i < cut; i++)
                        text_q.push_back(word[i]);
                end
                else if (pick < 65)
                begin
                    for (int i = 0; i < cut; i++)
                        text_q.push_back(word[i]);
                    text_q.push_back(xeu_pkg::CH_AMP);
                end
                else if (pick < 80)
                    text_q.push_back(word[$urandom_range(0, spell_len(which) - 1)]);
                else if (pick < 90)
                begin
                    hi = 8'($urandom_range(1, 255));
                    text_q.push_back({hi, word[$urandom_range(0, spell_len(which) - 1)][7:0]});
                end
                else
                    text_q.push_back(16'($urandom_range(0, 16'hFFFF)));
            end
            for (int i = 0; i < text_q.size(); i++)
                send_char(text_q[i], i == text_q.size() - 1);
            sent += text_q.size();
        end
    endtask

    task automatic test_calm_tail();
        idle_on = 1'b0;
        test_random_text(60);
        s_tvalid <= 1'b0;
        @(posedge clk);
        // a held sixth character only leaves with a further beat
        while (slot_vld)
        begin
            send_char(PLAIN_CH, 1'b1);
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 16'h0000;
        s_tlast  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_entities();
        test_quot_overflow();
        test_broken_match();
        test_wide_chars();
        test_random_text(380);
        test_calm_tail();

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (bad_count == 0 && expected_chars.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
